### hw/rtl/gart_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gart_pkg: shared types and constants
// Word formats, register codes, golden-mean phase constants, CORDIC table.
// ----------------------------------------------------------------------------
package gart_pkg;

  typedef struct packed {
    logic [15:0] spoke;
    logic [20:0] acq_index;
    logic [11:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] kx;
    logic signed [15:0] ky;
    logic signed [15:0] kz;
    logic               last;
  } out_word_t;

  // register indexes
  localparam logic [1:0] REG_DIMENSIONS  = 2'd0;
  localparam logic [1:0] REG_SAMPLES     = 2'd1;
  localparam logic [1:0] REG_ANGLE_MODE  = 2'd2;
  localparam logic [1:0] REG_SPOKE_COUNT = 2'd3;

  localparam logic [1:0]  DIM_2D          = 2'd2;
  localparam logic [1:0]  MODE_SPOKE      = 2'd0;
  localparam logic [1:0]  MODE_ACQ        = 2'd1;
  localparam logic [1:0]  MODE_PAIRED     = 2'd2;

  localparam logic [1:0]  DIM_RESET       = 2'd3;
  localparam logic [12:0] SAMPLES_RESET   = 13'd256;
  localparam logic [1:0]  MODE_RESET      = MODE_SPOKE;
  localparam logic [15:0] SPOKES_RESET    = 16'd256;

  // 48-bit fractions of 1/(2*phi) and the two golden means
  localparam logic [47:0] INV2PHI_48 = 48'h4F1BBCDCBFA5;
  localparam logic [47:0] GM1_48     = 48'd131046651649665;
  localparam logic [47:0] GM2_48     = 48'd192058202691525;

  localparam int                 CORDIC_STEPS = 24;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;

  // phase increment rounded to pb fraction bits
  function automatic logic [47:0] phase_step(input logic [47:0] c48, input int pb);
    logic [48:0] sum;
    int          sh;
    sh = 48 - pb;
    if (sh > 0) begin
      sum = {1'b0, c48} + (49'd1 << (sh - 1));
      phase_step = 48'(sum >> sh);
    end else begin
      phase_step = c48;
    end
  endfunction

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    case (i)
      0:  atan_turn = 32'd536870912;
      1:  atan_turn = 32'd316933406;
      2:  atan_turn = 32'd167458907;
      3:  atan_turn = 32'd85004756;
      4:  atan_turn = 32'd42667331;
      5:  atan_turn = 32'd21354465;
      6:  atan_turn = 32'd10679838;
      7:  atan_turn = 32'd5340245;
      8:  atan_turn = 32'd2670163;
      9:  atan_turn = 32'd1335087;
      10: atan_turn = 32'd667544;
      11: atan_turn = 32'd333772;
      12: atan_turn = 32'd166886;
      13: atan_turn = 32'd83443;
      14: atan_turn = 32'd41722;
      15: atan_turn = 32'd20861;
      16: atan_turn = 32'd10430;
      17: atan_turn = 32'd5215;
      18: atan_turn = 32'd2608;
      19: atan_turn = 32'd1304;
      20: atan_turn = 32'd652;
      21: atan_turn = 32'd326;
      22: atan_turn = 32'd163;
      23: atan_turn = 32'd81;
      default: atan_turn = 32'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

### hw/rtl/gart_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gart_div: pipelined radial divider
// floor(sa * 2^32 / n), one quotient bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module gart_div (
  input  wire logic        clk,
  input  wire logic [12:0] sa_i,
  input  wire logic [12:0] n_i,
  output logic      [31:0] q_o
);

  logic [12:0] rem_r [1:32];
  logic [31:0] quo_r [1:32];

  genvar i;
  generate
    for (i = 0; i < 32; i++) begin : g_stage
      logic [12:0] cur_rem;
      logic [31:0] cur_quo;
      logic [13:0] rem2;
      logic        ge;
      if (i == 0) begin : g_first
        assign cur_rem = sa_i;
        assign cur_quo = '0;
      end else begin : g_next
        assign cur_rem = rem_r[i];
        assign cur_quo = quo_r[i];
      end
      assign rem2 = {cur_rem, 1'b0};
      assign ge   = rem2 >= {1'b0, n_i};
      always_ff @(posedge clk) begin
        rem_r[i+1] <= ge ? 13'(rem2 - {1'b0, n_i}) : rem2[12:0];
        quo_r[i+1] <= {cur_quo[30:0], ge};
      end
    end
  endgenerate

  assign q_o = quo_r[32];

endmodule
`default_nettype wire

### hw/rtl/gart_phase.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gart_phase: golden-mean phase accumulator
// idx * step mod 2^PHASE_BITS in two halves, top 32 bits out. Two stages.
// ----------------------------------------------------------------------------
module gart_phase #(
  parameter int PHASE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic [20:0]           idx_i,
  input  wire logic [PHASE_BITS-1:0] step_i,
  output logic      [31:0]           phase_o
);

  localparam int LO_W = (PHASE_BITS + 1) / 2;
  localparam int HI_W = PHASE_BITS - LO_W;

  logic [21+LO_W-1:0]     plo_r;
  logic [21+HI_W-1:0]     phi_r;
  logic [PHASE_BITS-1:0]  ph_r;
  logic [PHASE_BITS-1:0]  ph_nxt;

  always_ff @(posedge clk) begin
    plo_r <= idx_i * step_i[LO_W-1:0];
    phi_r <= idx_i * step_i[PHASE_BITS-1:LO_W];
    ph_r  <= ph_nxt;
  end

  assign ph_nxt = PHASE_BITS'(plo_r) + PHASE_BITS'({phi_r, {LO_W{1'b0}}});

  generate
    if (PHASE_BITS >= 32) begin : g_wide
      assign phase_o = ph_r[PHASE_BITS-1 -: 32];
    end else begin : g_narrow
      assign phase_o = {ph_r, {(32-PHASE_BITS){1'b0}}};
    end
  endgenerate

endmodule
`default_nettype wire

### hw/rtl/gart_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gart_cordic: pipelined sine/cosine
// Quarter-turn reduction, 24 rotation stages, quadrant fold. 26 stages.
// ----------------------------------------------------------------------------
module gart_cordic (
  input  wire logic               clk,
  input  wire logic        [31:0] u_i,
  output logic signed      [33:0] cos_o,
  output logic signed      [33:0] sin_o
);

  localparam int N = gart_pkg::CORDIC_STEPS;

  logic signed [33:0] x_r [0:N];
  logic signed [33:0] y_r [0:N];
  logic signed [32:0] z_r [0:N];
  logic        [1:0]  q_r [0:N];
  logic signed [33:0] cos_r, sin_r;

  logic [31:0] u_plus;
  logic [1:0]  q0;
  logic [31:0] z0;

  assign u_plus = u_i + 32'h2000_0000;
  assign q0     = u_plus[31:30];
  assign z0     = u_i - {q0, 30'd0};

  always_ff @(posedge clk) begin
    x_r[0] <= gart_pkg::CORDIC_GAIN;
    y_r[0] <= '0;
    z_r[0] <= 33'($signed(z0));
    q_r[0] <= q0;
  end

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_rot
      localparam logic signed [32:0] ATAN = $signed({1'b0, gart_pkg::atan_turn(i)});
      logic signed [33:0] dx, dy;
      assign dx = y_r[i] >>> i;
      assign dy = x_r[i] >>> i;
      always_ff @(posedge clk) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][32]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    case (q_r[N])
      2'd0: begin
        cos_r <= x_r[N];
        sin_r <= y_r[N];
      end
      2'd1: begin
        cos_r <= -y_r[N];
        sin_r <= x_r[N];
      end
      2'd2: begin
        cos_r <= -x_r[N];
        sin_r <= -y_r[N];
      end
      default: begin
        cos_r <= y_r[N];
        sin_r <= -x_r[N];
      end
    endcase
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
`default_nettype wire

### hw/rtl/gart_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gart_sqrt: pipelined integer square root
// Digit-by-digit floor(sqrt(v)) for v < 2^63, one result bit per stage.
// ----------------------------------------------------------------------------
module gart_sqrt (
  input  wire logic        clk,
  input  wire logic [63:0] v_i,
  output logic      [31:0] root_o
);

  logic [63:0] v_r [1:32];
  logic [63:0] r_r [1:32];

  genvar i;
  generate
    for (i = 0; i < 32; i++) begin : g_stage
      localparam logic [63:0] BIT = 64'd1 << (62 - 2*i);
      logic [63:0] cur_v, cur_r, trial;
      if (i == 0) begin : g_first
        assign cur_v = v_i;
        assign cur_r = '0;
      end else begin : g_next
        assign cur_v = v_r[i];
        assign cur_r = r_r[i];
      end
      assign trial = cur_r + BIT;
      always_ff @(posedge clk) begin
        if (cur_v >= trial) begin
          v_r[i+1] <= cur_v - trial;
          r_r[i+1] <= (cur_r >> 1) + BIT;
        end else begin
          v_r[i+1] <= cur_v;
          r_r[i+1] <= cur_r >> 1;
        end
      end
    end
  endgenerate

  assign root_o = r_r[32][31:0];

endmodule
`default_nettype wire

### hw/rtl/golden_angle_radial_kspace_trajectory.sv
`default_nettype none
// ----------------------------------------------------------------------------
// golden_angle_radial_kspace_trajectory
// Radial k-space sample position from spoke, acquisition index and sample,
// planar golden angle (2D) or spherical golden means (3D).
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  input     start, busy, in_word           word taken when start & !busy
//  result    out_valid, out_word            one-cycle strobe, no backpressure
//  config    cfg_psel .. cfg_pready         APB, write on access phase
//
//  One word accepted every cycle; busy is always low.
//  The result strobe trails the accepting edge by the full depth: the 32-stage
//  square root (after phase and f^2) sets it; the 32-stage radius divider
//  is delayed to align; then two multiply stages, a round/saturate stage.
//  Reset clears only the valid chain and the registers; payload is unreset.
//  Nothing stalls: every stage advances each cycle.
// ----------------------------------------------------------------------------
module golden_angle_radial_kspace_trajectory #(
  parameter int MAX_SAMPLES = 4096,
  parameter int COORD_BITS  = 16,
  parameter int PHASE_BITS  = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire gart_pkg::in_word_t   in_word,
  // result channel
  output logic                      out_valid,
  output gart_pkg::out_word_t       out_word,
  // configuration
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [3:0]           cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  localparam int LAT     = 40;   // accept edge to result strobe
  localparam int SH      = 32 - COORD_BITS;
  localparam int B_DLY   = 4;    // divider done at stage 32
  localparam int CS_DLY  = 8;    // cordic done at stage 28
  localparam int F_DLY   = 34;   // f ready at stage 2
  localparam int L_DLY   = 36;   // last flag from stage 0

  localparam logic [47:0] STEP_INV_48 = gart_pkg::phase_step(gart_pkg::INV2PHI_48, PHASE_BITS);
  localparam logic [47:0] STEP_GM1_48 = gart_pkg::phase_step(gart_pkg::GM1_48, PHASE_BITS);
  localparam logic [47:0] STEP_GM2_48 = gart_pkg::phase_step(gart_pkg::GM2_48, PHASE_BITS);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]  dim_r,  dim_nxt;
  logic [12:0] spc_r,  spc_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] cnt_r,  cnt_nxt;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    dim_nxt  = dim_r;
    spc_nxt  = spc_r;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        gart_pkg::REG_DIMENSIONS:  dim_nxt  = cfg_pwdata[1:0];
        gart_pkg::REG_SAMPLES:     spc_nxt  = cfg_pwdata[12:0];
        gart_pkg::REG_ANGLE_MODE:  mode_nxt = cfg_pwdata[1:0];
        gart_pkg::REG_SPOKE_COUNT: cnt_nxt  = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      gart_pkg::REG_DIMENSIONS:  cfg_prdata = {30'd0, dim_r};
      gart_pkg::REG_SAMPLES:     cfg_prdata = {19'd0, spc_r};
      gart_pkg::REG_ANGLE_MODE:  cfg_prdata = {30'd0, mode_r};
      gart_pkg::REG_SPOKE_COUNT: cfg_prdata = {16'd0, cnt_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r  <= gart_pkg::DIM_RESET;
      spc_r  <= gart_pkg::SAMPLES_RESET;
      mode_r <= gart_pkg::MODE_RESET;
      cnt_r  <= gart_pkg::SPOKES_RESET;
    end else begin
      dim_r  <= dim_nxt;
      spc_r  <= spc_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // config must only change while idle (the block does not enforce this), so later stages read it directly
  logic is_2d;
  assign is_2d = dim_r == gart_pkg::DIM_2D;

  // --------------------------------------------------------------------------
  // stage 0: clamp N and sample, pick the angle index, flag the last word
  // --------------------------------------------------------------------------
  logic        accept;
  logic [12:0] n_eff;
  logic [12:0] sa_nxt, sa_r;
  logic [20:0] idx3;
  logic [20:0] idx_sc_nxt, idx_sc_r, idx_f_r;
  logic        last_nxt;
  logic [LAT-1:0] vld_r, vld_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    if (spc_r == 13'd0)
      n_eff = 13'd1;
    else if (32'(spc_r) > MAX_SAMPLES)
      n_eff = 13'(MAX_SAMPLES);
    else
      n_eff = spc_r;
    sa_nxt = ({1'b0, in_word.sample} < n_eff) ? {1'b0, in_word.sample} : n_eff - 13'd1;
    case (mode_r)
      gart_pkg::MODE_ACQ:    idx3 = in_word.acq_index - 21'd1;
      gart_pkg::MODE_PAIRED: idx3 = {6'd0, in_word.spoke[15:1]};
      default:               idx3 = {5'd0, in_word.spoke};
    endcase
    idx_sc_nxt = is_2d ? {5'd0, in_word.spoke} : idx3;
    last_nxt   = (17'(in_word.spoke) + 17'd1 == {1'b0, cnt_r}) &&
                 (14'(in_word.sample) + 14'd1 == {1'b0, n_eff});
  end

  assign vld_nxt = {vld_r[LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n)
      vld_r <= '0;
    else
      vld_r <= vld_nxt;
  end

  logic last_dly_r [0:L_DLY];

  always_ff @(posedge clk) begin
    sa_r          <= sa_nxt;
    idx_sc_r      <= idx_sc_nxt;
    idx_f_r       <= idx3;
    last_dly_r[0] <= last_nxt;
    for (int k = 1; k <= L_DLY; k++)
      last_dly_r[k] <= last_dly_r[k-1];
  end

  // --------------------------------------------------------------------------
  // radius, phases, sine/cosine, elevation root
  // --------------------------------------------------------------------------
  logic [31:0]        q_div;
  logic [31:0]        ph_sc, ph_f;
  logic signed [33:0] cos_w, sin_w;
  logic [31:0]        sq_w;
  logic [PHASE_BITS-1:0] step_sc;

  assign step_sc = is_2d ? STEP_INV_48[PHASE_BITS-1:0] : STEP_GM2_48[PHASE_BITS-1:0];

  gart_div u_div (
    .clk  (clk),
    .sa_i (sa_r),
    .n_i  (n_eff),
    .q_o  (q_div)
  );

  gart_phase #(.PHASE_BITS(PHASE_BITS)) u_phase_sc (
    .clk     (clk),
    .idx_i   (idx_sc_r),
    .step_i  (step_sc),
    .phase_o (ph_sc)
  );

  gart_phase #(.PHASE_BITS(PHASE_BITS)) u_phase_f (
    .clk     (clk),
    .idx_i   (idx_f_r),
    .step_i  (STEP_GM1_48[PHASE_BITS-1:0]),
    .phase_o (ph_f)
  );

  gart_cordic u_cordic (
    .clk   (clk),
    .u_i   (ph_sc),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  // f = top 31 phase bits; root of 2^62 - f^2
  logic [30:0] f_w;
  logic [61:0] ff_r;
  logic [63:0] rad_r;

  assign f_w = ph_f[31:1];

  always_ff @(posedge clk) begin
    ff_r  <= f_w * f_w;
    rad_r <= (64'd1 << 62) - 64'(ff_r);
  end

  gart_sqrt u_sqrt (
    .clk    (clk),
    .v_i    (rad_r),
    .root_o (sq_w)
  );

  // --------------------------------------------------------------------------
  // align everything to stage 36
  // --------------------------------------------------------------------------
  logic signed [32:0] b_w;
  logic signed [32:0] b_dly_r [0:B_DLY-1];
  logic signed [33:0] c_dly_r [0:CS_DLY-1];
  logic signed [33:0] s_dly_r [0:CS_DLY-1];
  logic        [30:0] f_dly_r [0:F_DLY-1];

  assign b_w = $signed({1'b0, q_div} - 33'h0_8000_0000);

  always_ff @(posedge clk) begin
    b_dly_r[0] <= b_w;
    c_dly_r[0] <= cos_w;
    s_dly_r[0] <= sin_w;
    f_dly_r[0] <= f_w;
    for (int k = 1; k < B_DLY; k++)
      b_dly_r[k] <= b_dly_r[k-1];
    for (int k = 1; k < CS_DLY; k++) begin
      c_dly_r[k] <= c_dly_r[k-1];
      s_dly_r[k] <= s_dly_r[k-1];
    end
    for (int k = 1; k < F_DLY; k++)
      f_dly_r[k] <= f_dly_r[k-1];
  end

  logic signed [32:0] b_al;
  logic signed [33:0] c_al, s_al;
  logic        [30:0] f_al;

  assign b_al = b_dly_r[B_DLY-1];
  assign c_al = c_dly_r[CS_DLY-1];
  assign s_al = s_dly_r[CS_DLY-1];
  assign f_al = f_dly_r[F_DLY-1];

  // --------------------------------------------------------------------------
  // stage 37: b*cos, b*sin, b*f
  // --------------------------------------------------------------------------
  logic signed [66:0] bc_full, bs_full;
  logic signed [64:0] bf_full;
  logic signed [35:0] bc_r, bs_r, bf_r;
  logic        [31:0] sq_r;
  logic               last37_r;

  assign bc_full = b_al * c_al;
  assign bs_full = b_al * s_al;
  assign bf_full = b_al * $signed({1'b0, f_al});

  always_ff @(posedge clk) begin
    bc_r     <= 36'(bc_full >>> 30);
    bs_r     <= 36'(bs_full >>> 30);
    bf_r     <= 36'(bf_full >>> 31);
    sq_r     <= sq_w;
    last37_r <= last_dly_r[L_DLY];
  end

  // --------------------------------------------------------------------------
  // stage 38: scale by sqrt(1-f^2) in 3D
  // --------------------------------------------------------------------------
  logic signed [68:0] xs_full, ys_full;
  logic signed [35:0] kx_r, ky_r, kz_r;
  logic               last38_r;

  assign xs_full = bc_r * $signed({1'b0, sq_r});
  assign ys_full = bs_r * $signed({1'b0, sq_r});

  always_ff @(posedge clk) begin
    kx_r     <= is_2d ? bc_r : 36'(xs_full >>> 31);
    ky_r     <= is_2d ? bs_r : 36'(ys_full >>> 31);
    kz_r     <= is_2d ? 36'sd0 : bf_r;
    last38_r <= last37_r;
  end

  // --------------------------------------------------------------------------
  // stage 39: round half up to 2^-COORD_BITS, saturate to 16 bits
  // --------------------------------------------------------------------------
  logic signed [36:0] kx_rnd, ky_rnd, kz_rnd;
  gart_pkg::out_word_t out_nxt, out_r;

  generate
    if (SH > 0) begin : g_round
      localparam logic signed [36:0] HALF = 37'sd1 <<< (SH - 1);
      assign kx_rnd = (37'(kx_r) + HALF) >>> SH;
      assign ky_rnd = (37'(ky_r) + HALF) >>> SH;
      assign kz_rnd = (37'(kz_r) + HALF) >>> SH;
    end else begin : g_exact
      assign kx_rnd = 37'(kx_r);
      assign ky_rnd = 37'(ky_r);
      assign kz_rnd = 37'(kz_r);
    end
  endgenerate

  function automatic logic signed [15:0] sat16(input logic signed [36:0] v);
    if (v > 37'sd32767)
      sat16 = 16'sh7FFF;
    else if (v < -37'sd32768)
      sat16 = 16'sh8000;
    else
      sat16 = v[15:0];
  endfunction

  always_comb begin
    out_nxt.kx   = sat16(kx_rnd);
    out_nxt.ky   = sat16(ky_rnd);
    out_nxt.kz   = sat16(kz_rnd);
    out_nxt.last = last38_r;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_word  = out_r;
  assign out_valid = vld_r[LAT-1];

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted word did not produce a result on time");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[36] |-> (sq_w <= 32'h8000_0000))
    else $error("elevation root above one");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

endmodule
`default_nettype wire
